// File: rtl/cumulative_ack_reorder_tracker_defines.svh
// Assertion macros for the cumulative ACK reorder tracker.
// No dependencies; included by modules that carry assertions.
`ifndef CUMULATIVE_ACK_REORDER_TRACKER_DEFINES_SVH
`define CUMULATIVE_ACK_REORDER_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CART_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define CART_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/cart_pkg.sv
// Shared types and constants for the cumulative ACK reorder tracker.
// No dependencies.
package cart_pkg;

  localparam int HOLD_DEPTH = 16;
  localparam int SEQ_WIDTH  = 32;

  localparam logic [1:0] OUT_IN_ORDER = 2'd0;
  localparam logic [1:0] OUT_HELD     = 2'd1;
  localparam logic [1:0] OUT_OLD      = 2'd2;
  localparam logic [1:0] OUT_DROPPED  = 2'd3;

  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_end;
  } seg_t;

  typedef struct packed {
    logic [31:0] ack_number;
    logic [1:0]  outcome;
  } ack_t;

endpackage

// File: rtl/cumulative_ack_reorder_tracker.sv
// The hold table memory has one read port and is scanned one entry per cycle. A first or old
// segment goes straight to the result; a gap segment waits for a full scan for a duplicate
// and a free entry; an in-order segment rescans after each entry it chains, then a repair
// scan frees stale entries. The back end takes one segment at a time; a two-entry queue and
// the ACK register let both sides stall independently. Reset (rst, synchronous): empty queue,
// no held entries, expected sequence zero, no first segment seen; no clearing pass.
module cumulative_ack_reorder_tracker #(
  parameter int HOLD_DEPTH = cart_pkg::HOLD_DEPTH,
  parameter int SEQ_WIDTH  = cart_pkg::SEQ_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            seg_valid,
  output logic            seg_ready,
  input  cart_pkg::seg_t  seg,
  output logic            ack_valid,
  input  logic            ack_ready,
  output cart_pkg::ack_t  ack
);

  logic           q_valid;
  logic           q_ready;
  cart_pkg::seg_t q_item;

  cart_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  cart_engine #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .SEQ_WIDTH  (SEQ_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .ack_valid (ack_valid),
    .ack_ready (ack_ready),
    .ack       (ack)
  );

endmodule

// File: rtl/cart_front.sv
// Input side: takes segment transfers into a two-entry queue.
// Depends on cart_pkg.
module cart_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            seg_valid,
  output logic            seg_ready,
  input  cart_pkg::seg_t  seg,
  output logic            q_valid,
  input  logic            q_ready,
  output cart_pkg::seg_t  q_item
);

  localparam logic [1:0] FULL = 2'd2;

  cart_pkg::seg_t slot [2];
  logic           wr_sel;
  logic           rd_sel;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign seg_ready = (count != FULL);
  assign q_valid   = (count != 2'd0);
  assign q_item    = slot[rd_sel];
  assign push      = seg_valid && seg_ready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/cart_engine.sv
// Back end: expected-sequence tracking, hold table scans and the ACK output register.
// Depends on cart_pkg and cumulative_ack_reorder_tracker_defines.svh.
`include "cumulative_ack_reorder_tracker_defines.svh"

module cart_engine #(
  parameter int HOLD_DEPTH = cart_pkg::HOLD_DEPTH,
  parameter int SEQ_WIDTH  = cart_pkg::SEQ_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  cart_pkg::seg_t  q_item,
  output logic            ack_valid,
  input  logic            ack_ready,
  output cart_pkg::ack_t  ack
);

  localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [CW-1:0] LAST = CW'(HOLD_DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHAIN  = 3'd1;
  localparam logic [2:0] ST_REPAIR = 3'd2;
  localparam logic [2:0] ST_GAP    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]            state;
  logic                  started;
  logic [SEQ_WIDTH-1:0]  exp_seq;
  logic [SEQ_WIDTH-1:0]  seg_s;
  logic [SEQ_WIDTH-1:0]  seg_e;
  logic [HOLD_DEPTH-1:0] valid;
  logic [SEQ_WIDTH-1:0]  mem_start [HOLD_DEPTH];
  logic [SEQ_WIDTH-1:0]  mem_end   [HOLD_DEPTH];
  logic [SEQ_WIDTH-1:0]  rd_start;
  logic [SEQ_WIDTH-1:0]  rd_end;
  logic [IW-1:0]         chk_idx;
  logic                  chk_live;
  logic [CW-1:0]         issue_cnt;
  logic                  dup;
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic [1:0]            outcome;

  logic                  pass_issue;
  logic                  pass_end;
  logic                  chk_valid;
  logic                  chain_hit;
  logic                  stale;
  logic                  mem_we;
  logic                  out_free;
  logic [IW-1:0]         rd_addr;
  logic [SEQ_WIDTH-1:0]  s_in;
  logic [SEQ_WIDTH-1:0]  e_in;

  assign q_ready    = (state == ST_IDLE);
  assign s_in       = SEQ_WIDTH'(q_item.seg_start);
  assign e_in       = SEQ_WIDTH'(q_item.seg_end);
  assign pass_issue = (issue_cnt != LAST);
  assign pass_end   = !pass_issue && !chk_live;
  assign chk_valid  = valid[chk_idx];
  assign chain_hit  = (state == ST_CHAIN) && chk_live && chk_valid && (rd_start == exp_seq);
  assign stale      = (state == ST_REPAIR) && chk_live && chk_valid && (rd_start < exp_seq);
  assign mem_we     = (state == ST_GAP) && pass_end && !dup && free_found;
  assign out_free   = !ack_valid || ack_ready;
  assign rd_addr    = pass_issue ? issue_cnt[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_start[free_idx] <= seg_s;
      mem_end[free_idx]   <= seg_e;
    end
    rd_start <= mem_start[rd_addr];
    rd_end   <= mem_end[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      exp_seq   <= '0;
      valid     <= '0;
      chk_live  <= 1'b0;
      issue_cnt <= '0;
      ack_valid <= 1'b0;
    end else begin
      if (ack_valid && ack_ready) begin
        ack_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            seg_s      <= s_in;
            seg_e      <= e_in;
            issue_cnt  <= '0;
            chk_live   <= 1'b0;
            dup        <= 1'b0;
            free_found <= 1'b0;
            if (!started) begin
              started <= 1'b1;
              exp_seq <= e_in;
              outcome <= cart_pkg::OUT_IN_ORDER;
              state   <= ST_RESULT;
            end else if (s_in == exp_seq) begin
              exp_seq <= e_in;
              outcome <= cart_pkg::OUT_IN_ORDER;
              state   <= ST_CHAIN;
            end else if (s_in > exp_seq) begin
              state <= ST_GAP;
            end else begin
              outcome <= cart_pkg::OUT_OLD;
              state   <= ST_RESULT;
            end
          end
        end
        ST_CHAIN, ST_REPAIR, ST_GAP: begin
          if (pass_issue) begin
            issue_cnt <= issue_cnt + CW'(1);
            chk_idx   <= issue_cnt[IW-1:0];
            chk_live  <= 1'b1;
          end else begin
            chk_live <= 1'b0;
          end
          if (state == ST_CHAIN) begin
            if (chain_hit) begin
              exp_seq        <= rd_end;
              valid[chk_idx] <= 1'b0;
              issue_cnt      <= '0;
              chk_live       <= 1'b0;
            end else if (pass_end) begin
              issue_cnt <= '0;
              state     <= ST_REPAIR;
            end
          end else if (state == ST_REPAIR) begin
            if (stale) begin
              valid[chk_idx] <= 1'b0;
            end
            if (pass_end) begin
              state <= ST_RESULT;
            end
          end else begin
            if (chk_live) begin
              if (chk_valid && (rd_start == seg_s)) begin
                dup <= 1'b1;
              end
              if (!chk_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
            end
            if (pass_end) begin
              if (mem_we) begin
                valid[free_idx] <= 1'b1;
                outcome         <= cart_pkg::OUT_HELD;
              end else begin
                outcome <= cart_pkg::OUT_DROPPED;
              end
              state <= ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            ack_valid      <= 1'b1;
            ack.ack_number <= 32'(exp_seq);
            ack.outcome    <= outcome;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CART_ASSERT_IMP(a_live_only_in_scan, clk, rst, chk_live, (state == ST_CHAIN) || (state == ST_REPAIR) || (state == ST_GAP))
  `CART_ASSERT_NEXT(a_hold_adds_one, clk, rst, mem_we, $countones(valid) == $past($countones(valid)) + 1)
  `CART_ASSERT_NEXT(a_repair_only_frees, clk, rst, state == ST_REPAIR, (valid & ~$past(valid)) == '0)
  `CART_ASSERT_NEXT(a_chain_restarts, clk, rst, chain_hit, (issue_cnt == '0) && !chk_live)
  `CART_ASSERT_NEXT(a_result_loads, clk, rst, (state == ST_RESULT) && out_free, ack_valid && (state == ST_IDLE))

endmodule
